FILE: design/bc_pkg.sv
`default_nettype none

package bc_pkg;

   localparam int DIV_W = 32;

   typedef enum logic [2:0] {
      CSR_AC123 = 3'd0,
      CSR_AC456 = 3'd1,
      CSR_B12   = 3'd2,
      CSR_MCMD  = 3'd3,
      CSR_OSS   = 3'd4
   } csr_index_type;

   localparam logic [31:0] TEMP_OFFSET  = 32'd4000;
   localparam logic [31:0] MG_COEFF     = 32'd3038;
   localparam logic [31:0] MH_COEFF     = 32'hFFFF_E343;
   localparam logic [31:0] MI_COEFF     = 32'd3791;
   localparam logic [31:0] B7_SCALE     = 32'd50000;
   localparam logic [31:0] B4_BIAS      = 32'd32768;
   localparam logic [31:0] TEMP_ROUND   = 32'd8;
   localparam logic [31:0] B_ROUND      = 32'd2;
   localparam logic [19:0] PRESSURE_MAX = 20'hFFFFF;

   typedef struct packed {
      logic [31:0] x1;
      logic [18:0] up;
      logic        neg;
      logic        fault;
   } side_a_type;

   typedef struct packed {
      logic [15:0] t;
      logic        fault;
      logic        dbl;
   } side_b_type;

   localparam int SIDE_W = $bits(side_a_type);
   localparam int SIDE_PAD = SIDE_W - $bits(side_b_type);

   function automatic logic [31:0] sx16(input logic [15:0] w);
      return {{16{w[15]}}, w};
   endfunction

   function automatic logic [31:0] mul32(input logic [31:0] a, input logic [31:0] b);
      logic [31:0] p;
      p = a * b;
      return p;
   endfunction

   function automatic logic [31:0] asr32(input logic [31:0] a, input int unsigned n);
      return $signed(a) >>> n;
   endfunction

   function automatic logic [31:0] abs32(input logic [31:0] a);
      return a[31] ? (32'd0 - a) : a;
   endfunction

endpackage

`default_nettype wire

FILE: design/barometer_compensation_top.sv
`default_nettype none

// Barometer compensation pipeline.
// Input channel req_*: one raw temperature and one raw pressure reading per
// transfer. Result channel rsp_*: compensated temperature (0.1 degC, signed,
// saturated), pressure (Pa, saturated) and a fault flag that is set, with both
// values zero, when a divisor was zero.
// Calibration words and the oversampling setting are written through csr_*
// (index 0..4); the user must write them only while no conversion is in
// flight, the block itself does not enforce this. Other indexes are ignored.
// Throughput: one conversion per cycle unless the receiver stalls. The path
// runs through two 33-stage restoring dividers (a load stage, then one
// quotient bit per stage) and ten arithmetic stages, the first loading at the transfer edge.
// Reset clears all valid bits and the calibration registers to zero.
// When the receiver stalls, the whole pipeline holds and req_ready drops; no
// conversion is lost or repeated.

module barometer_compensation_top import bc_pkg::*; (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [15:0] req_raw_temperature,
   input  wire logic [18:0] req_raw_pressure,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [15:0]      rsp_temperature,
   output logic [19:0]      rsp_pressure,
   output logic             rsp_fault,
   input  wire logic        csr_write,
   input  wire logic [2:0]  csr_index,
   input  wire logic [47:0] csr_wdata
);

   logic [47:0] ac123_ff, ac456_ff;
   logic [31:0] b12_ff, mcmd_ff;
   logic [1:0]  oss_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         ac123_ff <= '0;
         ac456_ff <= '0;
         b12_ff   <= '0;
         mcmd_ff  <= '0;
         oss_ff   <= '0;
      end else if (csr_write) begin
         case (csr_index)
            CSR_AC123: ac123_ff <= csr_wdata;
            CSR_AC456: ac456_ff <= csr_wdata;
            CSR_B12:   b12_ff   <= csr_wdata[31:0];
            CSR_MCMD:  mcmd_ff  <= csr_wdata[31:0];
            CSR_OSS:   oss_ff   <= csr_wdata[1:0];
            default: ;
         endcase
      end
   end

   logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, mc, md;
   assign ac1 = sx16(ac123_ff[47:32]);
   assign ac2 = sx16(ac123_ff[31:16]);
   assign ac3 = sx16(ac123_ff[15:0]);
   assign ac4 = {16'h0, ac456_ff[47:32]};
   assign ac5 = {16'h0, ac456_ff[31:16]};
   assign ac6 = {16'h0, ac456_ff[15:0]};
   assign b1  = sx16(b12_ff[31:16]);
   assign b2  = sx16(b12_ff[15:0]);
   assign mc  = sx16(mcmd_ff[31:16]);
   assign md  = sx16(mcmd_ff[15:0]);

   logic adv;
   assign adv       = !rsp_valid || rsp_ready;
   assign req_ready = adv;

   // stage 1
   logic        s1_valid_ff;
   logic [31:0] s1_prod_ff, s1_prod_in;
   logic [18:0] s1_up_ff;

   // divider A
   logic        da_valid;
   logic [31:0] da_num_in, da_den_in, da_quo, da_x1_in, da_dsum_in;
   logic [SIDE_W-1:0] da_side_out;
   side_a_type  da_side_in, da_side;

   // stage 3 .. 8
   logic        s3_valid_ff, s4_valid_ff, s5_valid_ff, s6_valid_ff, s7_valid_ff, s8_valid_ff;
   logic [15:0] s3_t_ff, s4_t_ff, s5_t_ff, s6_t_ff, s7_t_ff, s8_t_ff, s3_t_in;
   logic        s3_fault_ff, s4_fault_ff, s5_fault_ff, s6_fault_ff, s7_fault_ff, s8_fault_ff;
   logic [18:0] s3_up_ff, s4_up_ff, s5_up_ff, s6_up_ff;
   logic [31:0] s3_b6_ff, s3_b6_in, s3_b5_in, s3_t32_in, s3_x2_in;
   logic [31:0] s4_sq_ff, s4_ac2_ff, s4_ac3_ff;
   logic [31:0] s5_b2_ff, s5_b1_ff, s5_x2a_ff, s5_x1c_ff, s5_sq_in;
   logic [31:0] s6_b3_ff, s6_bias_ff, s6_b3_in, s6_bias_in, s6_x3_in, s6_x3b_in;
   logic [31:0] s7_b4p_ff, s7_b7d_ff;
   logic [31:0] s8_b4_ff, s8_b7_ff;

   // divider B
   logic        db_valid;
   logic [31:0] db_num_in, db_den_in, db_quo;
   logic [SIDE_W-1:0] db_side_out;
   side_b_type  db_side_in, db_side;

   // stage 9 .. 11
   logic        s9_valid_ff, s10_valid_ff;
   logic [15:0] s9_t_ff, s10_t_ff;
   logic        s9_fault_ff, s10_fault_ff;
   logic [31:0] s9_p_ff, s9_sqx_ff, s9_hp_ff, s9_p_in, s9_x1_in;
   logic [31:0] s10_p_ff, s10_m_ff, s10_x2_ff;
   logic [31:0] out_sum_in, out_p_in;

   logic        rsp_valid_ff;
   logic [15:0] rsp_temperature_ff, rsp_temperature_in;
   logic [19:0] rsp_pressure_ff, rsp_pressure_in;
   logic        rsp_fault_ff;

   always_comb begin
      s1_prod_in = mul32({16'h0, req_raw_temperature} - ac6, ac5);

      da_x1_in   = asr32(s1_prod_ff, 15);
      da_dsum_in = da_x1_in + md;
      da_num_in  = abs32(mc << 11);
      da_den_in  = (da_dsum_in == 32'd0) ? 32'd1 : abs32(da_dsum_in);
      da_side_in = '{x1: da_x1_in, up: s1_up_ff, neg: mc[31] ^ da_dsum_in[31],
                     fault: da_dsum_in == 32'd0};

      da_side   = side_a_type'(da_side_out);
      s3_x2_in  = da_side.neg ? (32'd0 - da_quo) : da_quo;
      s3_b5_in  = da_side.x1 + s3_x2_in;
      s3_t32_in = asr32(s3_b5_in + TEMP_ROUND, 4);
      s3_b6_in  = s3_b5_in - TEMP_OFFSET;
      if ($signed(s3_t32_in) > 32'sd32767) begin
         s3_t_in = 16'h7FFF;
      end else if ($signed(s3_t32_in) < -32'sd32768) begin
         s3_t_in = 16'h8000;
      end else begin
         s3_t_in = s3_t32_in[15:0];
      end

      s5_sq_in = asr32(s4_sq_ff, 12);

      s6_x3_in   = asr32(s5_b2_ff, 11) + s5_x2a_ff;
      s6_b3_in   = asr32((((ac1 << 2) + s6_x3_in) << oss_ff) + B_ROUND, 2);
      s6_x3b_in  = asr32(s5_x1c_ff + asr32(s5_b1_ff, 16) + B_ROUND, 2);
      s6_bias_in = s6_x3b_in + B4_BIAS;

      db_num_in  = s8_b7_ff[31] ? s8_b7_ff : (s8_b7_ff << 1);
      db_den_in  = (s8_b4_ff == 32'd0) ? 32'd1 : s8_b4_ff;
      db_side_in = '{t: s8_t_ff, fault: s8_fault_ff || (s8_b4_ff == 32'd0),
                     dbl: s8_b7_ff[31]};

      db_side  = side_b_type'(db_side_out[$bits(side_b_type)-1:0]);
      s9_p_in  = db_side.dbl ? (db_quo << 1) : db_quo;
      s9_x1_in = asr32(s9_p_in, 8);

      out_sum_in = asr32(s10_m_ff, 16) + s10_x2_ff + MI_COEFF;
      out_p_in   = s10_p_ff + asr32(out_sum_in, 4);
      if (s10_fault_ff) begin
         rsp_temperature_in = '0;
         rsp_pressure_in    = '0;
      end else begin
         rsp_temperature_in = s10_t_ff;
         if (out_p_in[31]) begin
            rsp_pressure_in = '0;
         end else if (out_p_in > {12'h0, PRESSURE_MAX}) begin
            rsp_pressure_in = PRESSURE_MAX;
         end else begin
            rsp_pressure_in = out_p_in[19:0];
         end
      end
   end

   bc_div u_div_a (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s1_valid_ff),
      .in_num    (da_num_in),
      .in_den    (da_den_in),
      .in_side   (SIDE_W'(da_side_in)),
      .out_valid (da_valid),
      .out_quo   (da_quo),
      .out_side  (da_side_out)
   );

   bc_div u_div_b (
      .clock     (clock),
      .reset     (reset),
      .en        (adv),
      .in_valid  (s8_valid_ff),
      .in_num    (db_num_in),
      .in_den    (db_den_in),
      .in_side   ({{SIDE_PAD{1'b0}}, db_side_in}),
      .out_valid (db_valid),
      .out_quo   (db_quo),
      .out_side  (db_side_out)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         s3_valid_ff  <= 1'b0;
         s4_valid_ff  <= 1'b0;
         s5_valid_ff  <= 1'b0;
         s6_valid_ff  <= 1'b0;
         s7_valid_ff  <= 1'b0;
         s8_valid_ff  <= 1'b0;
         s9_valid_ff  <= 1'b0;
         s10_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_valid_ff  <= req_valid;
         s3_valid_ff  <= da_valid;
         s4_valid_ff  <= s3_valid_ff;
         s5_valid_ff  <= s4_valid_ff;
         s6_valid_ff  <= s5_valid_ff;
         s7_valid_ff  <= s6_valid_ff;
         s8_valid_ff  <= s7_valid_ff;
         s9_valid_ff  <= db_valid;
         s10_valid_ff <= s9_valid_ff;
         rsp_valid_ff <= s10_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s1_prod_ff <= s1_prod_in;
         s1_up_ff   <= req_raw_pressure;

         s3_t_ff     <= s3_t_in;
         s3_fault_ff <= da_side.fault;
         s3_up_ff    <= da_side.up;
         s3_b6_ff    <= s3_b6_in;

         s4_t_ff     <= s3_t_ff;
         s4_fault_ff <= s3_fault_ff;
         s4_up_ff    <= s3_up_ff;
         s4_sq_ff    <= mul32(s3_b6_ff, s3_b6_ff);
         s4_ac2_ff   <= mul32(ac2, s3_b6_ff);
         s4_ac3_ff   <= mul32(ac3, s3_b6_ff);

         s5_t_ff     <= s4_t_ff;
         s5_fault_ff <= s4_fault_ff;
         s5_up_ff    <= s4_up_ff;
         s5_b2_ff    <= mul32(b2, s5_sq_in);
         s5_b1_ff    <= mul32(b1, s5_sq_in);
         s5_x2a_ff   <= asr32(s4_ac2_ff, 11);
         s5_x1c_ff   <= asr32(s4_ac3_ff, 13);

         s6_t_ff     <= s5_t_ff;
         s6_fault_ff <= s5_fault_ff;
         s6_up_ff    <= s5_up_ff;
         s6_b3_ff    <= s6_b3_in;
         s6_bias_ff  <= s6_bias_in;

         s7_t_ff     <= s6_t_ff;
         s7_fault_ff <= s6_fault_ff;
         s7_b4p_ff   <= mul32(ac4, s6_bias_ff);
         s7_b7d_ff   <= {13'h0, s6_up_ff} - s6_b3_ff;

         s8_t_ff     <= s7_t_ff;
         s8_fault_ff <= s7_fault_ff;
         s8_b4_ff    <= s7_b4p_ff >> 15;
         s8_b7_ff    <= mul32(s7_b7d_ff, B7_SCALE >> oss_ff);

         s9_t_ff     <= db_side.t;
         s9_fault_ff <= db_side.fault;
         s9_p_ff     <= s9_p_in;
         s9_sqx_ff   <= mul32(s9_x1_in, s9_x1_in);
         s9_hp_ff    <= mul32(s9_p_in, MH_COEFF);

         s10_t_ff     <= s9_t_ff;
         s10_fault_ff <= s9_fault_ff;
         s10_p_ff     <= s9_p_ff;
         s10_m_ff     <= mul32(s9_sqx_ff, MG_COEFF);
         s10_x2_ff    <= asr32(s9_hp_ff, 16);

         rsp_temperature_ff <= rsp_temperature_in;
         rsp_pressure_ff    <= rsp_pressure_in;
         rsp_fault_ff       <= s10_fault_ff;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_temperature = rsp_temperature_ff;
   assign rsp_pressure    = rsp_pressure_ff;
   assign rsp_fault       = rsp_fault_ff;

endmodule

`default_nettype wire

FILE: design/bc_div.sv
`default_nettype none

module bc_div import bc_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              en,
   input  wire logic              in_valid,
   input  wire logic [DIV_W-1:0]  in_num,
   input  wire logic [DIV_W-1:0]  in_den,
   input  wire logic [SIDE_W-1:0] in_side,
   output logic                   out_valid,
   output logic [DIV_W-1:0]       out_quo,
   output logic [SIDE_W-1:0]      out_side
);

   logic              val_ff  [0:DIV_W];
   logic [DIV_W-1:0]  rem_ff  [0:DIV_W];
   logic [DIV_W-1:0]  num_ff  [0:DIV_W];
   logic [DIV_W-1:0]  den_ff  [0:DIV_W];
   logic [DIV_W-1:0]  quo_ff  [0:DIV_W];
   logic [SIDE_W-1:0] side_ff [0:DIV_W];

   always_ff @(posedge clock) begin
      if (reset) begin
         val_ff[0] <= 1'b0;
      end else if (en) begin
         val_ff[0] <= in_valid;
      end
      if (en) begin
         rem_ff[0]  <= '0;
         num_ff[0]  <= in_num;
         den_ff[0]  <= in_den;
         quo_ff[0]  <= '0;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 1; k <= DIV_W; k++) begin : g_step
      logic [DIV_W:0]   trial_in;
      logic             ge_in;
      logic [DIV_W-1:0] rem_in;

      always_comb begin
         trial_in = {rem_ff[k-1], num_ff[k-1][DIV_W-1]};
         ge_in    = trial_in >= {1'b0, den_ff[k-1]};
         rem_in   = ge_in ? DIV_W'(trial_in - {1'b0, den_ff[k-1]}) : trial_in[DIV_W-1:0];
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[k] <= 1'b0;
         end else if (en) begin
            val_ff[k] <= val_ff[k-1];
         end
         if (en) begin
            rem_ff[k]  <= rem_in;
            num_ff[k]  <= {num_ff[k-1][DIV_W-2:0], 1'b0};
            den_ff[k]  <= den_ff[k-1];
            quo_ff[k]  <= {quo_ff[k-1][DIV_W-2:0], ge_in};
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   assign out_valid = val_ff[DIV_W];
   assign out_quo   = quo_ff[DIV_W];
   assign out_side  = side_ff[DIV_W];

endmodule

`default_nettype wire

FILE: design/bc_checker.sv
`default_nettype none

module bc_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [15:0] rsp_temperature,
   input wire logic [19:0] rsp_pressure,
   input wire logic        rsp_fault
);

   a_reset_empty: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_temperature) && $stable(rsp_pressure)
         && $stable(rsp_fault))
      else $error("result changed while stalled");

   a_fault_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fault |-> rsp_temperature == 16'd0 && rsp_pressure == 20'd0)
      else $error("fault result carries nonzero values");

   a_ready_stall: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid && !rsp_ready)
      else $error("input held off without an output stall");

endmodule

bind barometer_compensation_top bc_checker u_bc_checker (.*);

`default_nettype wire
